// ----- sv/fat_cluster_chain_follower_macros.svh -----
// Assertion macros for the FAT cluster chain follower.
// Used by the top level; expects clk and arst_n in scope.
`ifndef FAT_CLUSTER_CHAIN_FOLLOWER_MACROS_SVH
`define FAT_CLUSTER_CHAIN_FOLLOWER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FCCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define FCCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/fccf_pkg.sv -----
// Shared types and constants of the FAT cluster chain follower.
// No dependencies.
package fccf_pkg;

	localparam int WORD_W    = 32;
	localparam int BASE_W    = 48;
	localparam int TBYTES_W  = 32;
	localparam int COUNT_W   = 28;
	localparam int CSIZE_W   = 26;
	localparam int OFFSET_W  = 64;
	localparam int TADDR_W   = 49;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int PROD_W    = WORD_W + CSIZE_W;

	localparam int ENTRY_BYTES = 4;
	localparam logic [WORD_W-1:0] FIRST_CLUSTER = 32'd2;
	localparam logic [WORD_W-1:0] END_MARKER    = 32'd268435448;
	localparam logic [WORD_W-1:0] ENTRY_MASK    = 32'h0FFF_FFFF;
	localparam logic [CSIZE_W-1:0] CSIZE_RESET  = 26'd512;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
	localparam int OCC_W     = $clog2(RES_DEPTH + 3);

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BYTES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SIZE  = 3'd4;

	typedef enum logic [2:0] {
		ST_CLUSTER     = 3'd0,
		ST_END         = 3'd1,
		ST_BROKEN      = 3'd2,
		ST_TABLE_RANGE = 3'd3,
		ST_TOO_LONG    = 3'd4,
		ST_READ_ERROR  = 3'd5,
		ST_IDLE        = 3'd6
	} status_t;

	typedef struct packed {
		logic [BASE_W-1:0]   table_base;
		logic [TBYTES_W-1:0] table_bytes;
		logic [COUNT_W-1:0]  cluster_count;
		logic [BASE_W-1:0]   data_base;
		logic [CSIZE_W-1:0]  cluster_size;
	} cfg_t;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   cluster;
		logic [COUNT_W-1:0]  chain;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   cluster;
		logic [OFFSET_W-1:0] offset;
		logic [TADDR_W-1:0]  taddr;
		logic [COUNT_W-1:0]  chain;
	} result_t;

endpackage

// ----- sv/fccf_front.sv -----
// Front end: classifies each accepted transaction and keeps the walk state.
// Depends on fccf_pkg.
module fccf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fccf_pkg::cfg_t               cfg,
	input  logic                         accept,
	input  logic                         req_type,
	input  logic [fccf_pkg::WORD_W-1:0]  word,
	input  logic                         read_failed,
	output fccf_pkg::cmd_t               cmd
);
	import fccf_pkg::*;

	logic               walking_q;
	logic [COUNT_W-1:0] emitted_q;
	logic               walking_d;
	logic [COUNT_W-1:0] emitted_d;
	logic               is_start;
	logic [WORD_W-1:0]  cand;
	logic [COUNT_W-1:0] count_base;
	logic [COUNT_W-1:0] count_inc;
	logic               in_range;
	logic [WORD_W+2:0]  rel_end;
	logic               range_bad;

	always_comb begin
		is_start   = (req_type == REQ_START);
		cand       = is_start ? word : (word & ENTRY_MASK);
		count_base = is_start ? '0 : emitted_q;
		count_inc  = count_base + COUNT_W'(1);
		in_range   = (cand >= FIRST_CLUSTER) &&
			((WORD_W+1)'(cand) < (WORD_W+1)'(cfg.cluster_count) + (WORD_W+1)'(FIRST_CLUSTER));
		rel_end    = (WORD_W+3)'(cand) * (WORD_W+3)'(ENTRY_BYTES) + (WORD_W+3)'(ENTRY_BYTES);
		range_bad  = rel_end > (WORD_W+3)'(cfg.table_bytes);

		walking_d   = 1'b0;
		emitted_d   = count_base;
		cmd.status  = ST_IDLE;
		cmd.cluster = cand;
		cmd.chain   = count_base;
		if (!is_start && !walking_q) begin
			walking_d   = walking_q;
			cmd.status  = ST_IDLE;
			cmd.cluster = '0;
		end else if (!is_start && read_failed) begin
			cmd.status  = ST_READ_ERROR;
			cmd.cluster = '0;
		end else if (in_range) begin
			if (count_base >= cfg.cluster_count) begin
				cmd.status = ST_TOO_LONG;
			end else begin
				emitted_d = count_inc;
				cmd.chain = count_inc;
				if (range_bad) begin
					cmd.status = ST_TABLE_RANGE;
				end else begin
					cmd.status = ST_CLUSTER;
					walking_d  = 1'b1;
				end
			end
		end else if (cand >= END_MARKER) begin
			cmd.status = ST_END;
		end else begin
			cmd.status = ST_BROKEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			emitted_q <= '0;
		end else if (accept) begin
			walking_q <= walking_d;
			emitted_q <= emitted_d;
		end
	end

endmodule

// ----- sv/fccf_cmd_queue.sv -----
// Short queue of classified transactions between front and back.
// Depends on fccf_pkg.
module fccf_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fccf_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output fccf_pkg::cmd_t dout,
	output logic           empty
);
	import fccf_pkg::*;

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			count_q <= count_q + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
		end
	end

endmodule

// ----- sv/fccf_back.sv -----
// Back end: offset multiply, address adds and the result queue.
// Depends on fccf_pkg.
module fccf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fccf_pkg::cfg_t    cfg,
	input  logic              cmd_avail,
	input  fccf_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              pop,
	output fccf_pkg::result_t result,
	output logic              empty
);
	import fccf_pkg::*;

	logic                 v_s1;
	logic                 v_s2;
	cmd_t                 cmd_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic [TADDR_W-1:0]   taddr_s1;
	result_t              res_s2;
	result_t              res_d;
	logic [OFFSET_W-1:0]  offset_sum;

	result_t              mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;
	logic [OCC_W-1:0]     occ;
	logic                 do_pop;

	assign occ     = OCC_W'(count_q) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign cmd_pop = cmd_avail && (occ < OCC_W'(RES_DEPTH));
	assign empty   = (count_q == '0);
	assign do_pop  = pop && !empty;
	assign result  = mem_q[rd_ptr_q];

	always_comb begin
		offset_sum     = OFFSET_W'(cfg.data_base) + OFFSET_W'(prod_s1);
		res_d.status   = cmd_s1.status;
		res_d.cluster  = cmd_s1.cluster;
		res_d.chain    = cmd_s1.chain;
		res_d.offset   = (cmd_s1.status == ST_CLUSTER) ? offset_sum : '0;
		res_d.taddr    = (cmd_s1.status == ST_CLUSTER || cmd_s1.status == ST_TABLE_RANGE)
			? taddr_s1 : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1   <= cmd;
			prod_s1  <= PROD_W'(cmd.cluster - FIRST_CLUSTER) * PROD_W'(cfg.cluster_size);
			taddr_s1 <= TADDR_W'(cfg.table_base)
				+ TADDR_W'(cmd.cluster) * TADDR_W'(ENTRY_BYTES);
		end
		if (v_s1) begin
			res_s2 <= res_d;
		end
		if (v_s2) begin
			mem_q[wr_ptr_q] <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			v_s1 <= cmd_pop;
			v_s2 <= v_s1;
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + RES_CNT_W'(v_s2) - RES_CNT_W'(do_pop);
		end
	end

endmodule

// ----- sv/fat_cluster_chain_follower.sv -----
// Top level of the FAT cluster chain follower: configuration registers,
// front end, command queue and back end. Depends on fccf_pkg and the macros header.
//
// Usage:
//   Input channel (push/full): req_type 0 starts a chain at cluster word;
//   req_type 1 returns the table entry fetched at the last table_address,
//   with read_failed set if it failed. One transaction per cycle unless full.
//   Result channel (empty/pop): exactly one result per input transaction, in
//   order; the oldest result is on the ports while empty is low.
//   Path: an accepted transaction is written to the command queue; the
//   back end draws it while the result queue has room (command read with
//   offset multiply and address add, offset add, result queue write).
//   Throughput: one transaction per cycle while full is low, set by the
//   combinational classification loop on the walk state.
//   Stall: when pop is held low the result queue fills, the back end stops
//   drawing commands, the command queue fills and full goes high.
//   Reset: clears the walk state, both queues and the configuration
//   (cluster_size returns to 512, the rest to zero).
//   Configuration: write while idle; unused indexes are ignored.
`include "fat_cluster_chain_follower_macros.svh"

module fat_cluster_chain_follower (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [fccf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fccf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic                              req_type,
	input  logic [fccf_pkg::WORD_W-1:0]       word,
	input  logic                              read_failed,
	output logic                              empty,
	input  logic                              pop,
	output logic [2:0]                        status,
	output logic [fccf_pkg::WORD_W-1:0]       cluster_number,
	output logic [fccf_pkg::OFFSET_W-1:0]     data_offset,
	output logic [fccf_pkg::TADDR_W-1:0]      table_address,
	output logic [fccf_pkg::COUNT_W-1:0]      chain_length
);
	import fccf_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    accept;
	logic    cmd_empty;
	logic    cmd_pop;
	result_t result;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_base    <= '0;
			cfg_q.table_bytes   <= '0;
			cfg_q.cluster_count <= '0;
			cfg_q.data_base     <= '0;
			cfg_q.cluster_size  <= CSIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TABLE_BASE:    cfg_q.table_base    <= cfg_data[BASE_W-1:0];
				CFG_TABLE_BYTES:   cfg_q.table_bytes   <= cfg_data[TBYTES_W-1:0];
				CFG_CLUSTER_COUNT: cfg_q.cluster_count <= cfg_data[COUNT_W-1:0];
				CFG_DATA_BASE:     cfg_q.data_base     <= cfg_data[BASE_W-1:0];
				CFG_CLUSTER_SIZE:  cfg_q.cluster_size  <= cfg_data[CSIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fccf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.req_type    (req_type),
		.word        (word),
		.read_failed (read_failed),
		.cmd         (cmd_in)
	);

	fccf_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	fccf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_avail (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.result    (result),
		.empty     (empty)
	);

	assign status         = result.status;
	assign cluster_number = result.cluster;
	assign data_offset    = result.offset;
	assign table_address  = result.taddr;
	assign chain_length   = result.chain;

	`FCCF_ASSERT(a_offset_only_cluster,
		!empty && status != ST_CLUSTER |-> data_offset == '0,
		"data offset on a non-cluster result")
	`FCCF_ASSERT(a_addr_only_fetch,
		!empty && status != ST_CLUSTER && status != ST_TABLE_RANGE |-> table_address == '0,
		"table address on a result without one")
	`FCCF_ASSERT(a_no_cluster_on_fault,
		!empty && (status == ST_IDLE || status == ST_READ_ERROR) |-> cluster_number == '0,
		"cluster number on an idle or read error result")
	`FCCF_ASSERT_NEXT(a_accept_fills_queue, accept,
		!cmd_empty || cmd_pop || $past(cmd_pop),
		"accepted transaction lost before the back end")

endmodule
